[design/ufb_pkg.sv]
// Package for the UDP/IPv4 frame builder: header layout constants, the
// marker letter table, register indexes and the shared structs.
// No dependencies.
`default_nettype none

package ufb_pkg;

    localparam int MAX_PAYLOAD_DEF = 1458;
    localparam int HDR_BYTES       = 56;
    localparam int ETH_BYTES       = 14;
    localparam int IP_BYTES        = 20;
    localparam int HDR_IDX_W       = $clog2(HDR_BYTES);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

    localparam int LEN_W      = 11;
    localparam int IN_DATA_W  = 56;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    // Fixed IPv4 header words: version/IHL+TOS, flags, TTL+protocol
    localparam logic [15:0] IP_W_VER   = 16'h4500;
    localparam logic [15:0] IP_W_FLAGS = 16'h4000;
    localparam logic [15:0] IP_W_TTLPR = 16'h1e11;
    localparam logic [15:0] IP_LEN_ADD  = 16'(HDR_BYTES - ETH_BYTES);
    localparam logic [15:0] UDP_LEN_ADD = 16'(HDR_BYTES - ETH_BYTES - IP_BYTES);

    localparam logic [7:0] ETH_TYPE_HI = 8'h08;

    localparam logic [7:0] MARKER [8] = '{8'h42, 8'h6f, 8'h6b, 8'h61,
                                         8'h4d, 8'h61, 8'h72, 8'h65};

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_DEST_MAC    = 3'd0,
        REG_SOURCE_MAC  = 3'd1,
        REG_SOURCE_IP   = 3'd2,
        REG_DEST_IP     = 3'd3,
        REG_SRC_PORT    = 3'd4,
        REG_DEST_PORT   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] src_port;
        logic [15:0] dest_port;
    } cfg_t;

    typedef struct packed {
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] cksum;
        logic [31:0] seq_number;
    } hdr_ctx_t;

endpackage

`default_nettype wire

[design/udp_ipv4_frame_builder.sv]
// Ethernet/IPv4/UDP frame builder, top level. A start beat gives a 56-beat
// header burst (one beat per cycle while the receiver is ready, input held
// off meanwhile by the header-active flag); a data beat gives one output beat
// in the cycle after acceptance, one per cycle while the receiver is ready.
// Reset (rst_n, asynchronous, active low) clears configuration, idles the
// frame state and empties the output register.
`default_nettype none

module udp_ipv4_frame_builder
    import ufb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // payload_len[10:0], seq_number[42:11],
                                                 // payload_byte[50:43], zero pad
    input  wire logic                  s_tuser,  // op
    // output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [7:0]            m_tdata,  // frame_byte
    output logic                       m_tlast,  // frame_last
    output logic                       m_tuser   // overrun
);

    cfg_t        cfg;
    logic [19:0] ck_base;

    // Header burst state
    logic                 hdr_active_reg, hdr_active_next;
    logic [HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    hdr_ctx_t             ctx_reg, ctx_next;
    logic                 empty_reg, empty_next;   // frame has no payload
    logic [LEN_W-1:0]     bytes_left_reg, bytes_left_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;
    logic       m_user_reg, m_user_next;

    logic             out_free;
    logic             accept;
    op_t              op;
    logic [LEN_W-1:0] plen_in;
    logic [LEN_W-1:0] plen_sat;
    logic [7:0]       pbyte_in;
    logic [7:0]       hdr_byte;
    logic [19:0]      ck_sum;
    logic [16:0]      ck_fold1;
    logic [15:0]      ck_fold2;

    ufb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .ck_base (ck_base)
    );

    ufb_hdr_gen u_hdr (
        .cfg      (cfg),
        .ctx      (ctx_reg),
        .idx      (hdr_idx_reg),
        .hdr_byte (hdr_byte)
    );

    assign pready = 1'b1;

    // The output register is free when empty or being drained this cycle;
    // hold input off for the whole header burst.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = out_free && !hdr_active_reg;
    assign accept   = s_tvalid && s_tready;

    assign op       = op_t'(s_tuser);
    assign plen_in  = s_tdata[LEN_W-1:0];
    assign pbyte_in = s_tdata[50:43];
    assign plen_sat = (32'(plen_in) > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : plen_in;

    // One's-complement fold of the header sum; the result settles long before
    // the checksum bytes leave, as they sit mid-way through the burst.
    assign ck_sum   = ck_base + 20'(ctx_reg.ip_len);
    assign ck_fold1 = 17'(ck_sum[15:0]) + 17'(ck_sum[19:16]);
    assign ck_fold2 = ck_fold1[15:0] + 16'(ck_fold1[16]);

    always_comb
    begin
        hdr_active_next = hdr_active_reg;
        hdr_idx_next    = hdr_idx_reg;
        ctx_next        = ctx_reg;
        empty_next      = empty_reg;
        bytes_left_next = bytes_left_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_user_next     = m_user_reg;

        if (hdr_active_reg)
        begin
            ctx_next.cksum = ~ck_fold2;
        end

        priority if (hdr_active_reg && out_free)
        begin
            // Advance the header burst by one beat
            m_valid_next = 1'b1;
            m_data_next  = hdr_byte;
            m_last_next  = empty_reg && (hdr_idx_reg == HDR_LAST_IDX);
            m_user_next  = 1'b0;
            hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
            if (hdr_idx_reg == HDR_LAST_IDX)
            begin
                hdr_active_next = 1'b0;
            end
        end
        else if (accept)
        begin
            unique case (op)
                OP_START:
                begin
                    // Abandon any unfinished frame and latch the new header
                    hdr_active_next     = 1'b1;
                    hdr_idx_next        = '0;
                    ctx_next.ip_len     = 16'(plen_sat) + IP_LEN_ADD;
                    ctx_next.udp_len    = 16'(plen_sat) + UDP_LEN_ADD;
                    ctx_next.seq_number = s_tdata[42:11];
                    empty_next          = (plen_sat == '0);
                    bytes_left_next     = plen_sat;
                    m_valid_next        = 1'b0;
                end
                OP_DATA:
                begin
                    m_valid_next = 1'b1;
                    if (bytes_left_reg == '0)
                    begin
                        // Drop the surplus byte and flag it
                        m_data_next = 8'h00;
                        m_last_next = 1'b0;
                        m_user_next = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - LEN_W'(1);
                        m_data_next     = pbyte_in;
                        m_last_next     = (bytes_left_reg == LEN_W'(1));
                        m_user_next     = 1'b0;
                    end
                end
                default:
                begin
                    m_valid_next = m_valid_reg;
                end
            endcase
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            // Hold the waiting beat
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_active_reg <= 1'b0;
            hdr_idx_reg    <= '0;
            bytes_left_reg <= '0;
            empty_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            hdr_active_reg <= hdr_active_next;
            hdr_idx_reg    <= hdr_idx_next;
            bytes_left_reg <= bytes_left_next;
            empty_reg      <= empty_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg    <= ctx_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

[design/ufb_cfg_regs.sv]
// Configuration register file of the frame builder behind the APB port.
// Also holds the registered partial IPv4 checksum of the fixed header words.
// Depends on ufb_pkg.
`default_nettype none

module ufb_cfg_regs
    import ufb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output cfg_t                       cfg,
    output logic      [19:0]           ck_base
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [19:0] ck_base_reg;
    logic [19:0] ck_base_next;
    reg_idx_t    idx;
    logic        wr_en;

    assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_DEST_MAC:    cfg_next.dest_mac    = pwdata[47:0];
                REG_SOURCE_MAC:  cfg_next.source_mac  = pwdata[47:0];
                REG_SOURCE_IP:   cfg_next.source_ip   = pwdata[31:0];
                REG_DEST_IP:     cfg_next.dest_ip     = pwdata[31:0];
                REG_SRC_PORT:    cfg_next.src_port    = pwdata[15:0];
                REG_DEST_PORT:   cfg_next.dest_port   = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Sum of the header words that do not depend on the payload length
    always_comb
    begin
        ck_base_next = 20'(IP_W_VER) + 20'(IP_W_FLAGS) + 20'(IP_W_TTLPR)
                     + 20'(cfg_reg.source_ip[31:16]) + 20'(cfg_reg.source_ip[15:0])
                     + 20'(cfg_reg.dest_ip[31:16]) + 20'(cfg_reg.dest_ip[15:0]);
    end

    always_comb
    begin
        case (idx)
            REG_DEST_MAC:    prdata = 64'(cfg_reg.dest_mac);
            REG_SOURCE_MAC:  prdata = 64'(cfg_reg.source_mac);
            REG_SOURCE_IP:   prdata = 64'(cfg_reg.source_ip);
            REG_DEST_IP:     prdata = 64'(cfg_reg.dest_ip);
            REG_SRC_PORT:    prdata = 64'(cfg_reg.src_port);
            REG_DEST_PORT:   prdata = 64'(cfg_reg.dest_port);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            ck_base_reg <= '0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            ck_base_reg <= ck_base_next;
        end
    end

    assign cfg     = cfg_reg;
    assign ck_base = ck_base_reg;

endmodule

`default_nettype wire

[design/ufb_hdr_gen.sv]
// Header byte selector: picks one of the 56 header bytes by position.
// Depends on ufb_pkg.
`default_nettype none

module ufb_hdr_gen
    import ufb_pkg::*;
(
    input  wire cfg_t                  cfg,
    input  wire hdr_ctx_t              ctx,
    input  wire logic [HDR_IDX_W-1:0]  idx,
    output logic      [7:0]            hdr_byte
);

    always_comb
    begin
        unique case (idx)
            6'd0:  hdr_byte = cfg.dest_mac[47:40];
            6'd1:  hdr_byte = cfg.dest_mac[39:32];
            6'd2:  hdr_byte = cfg.dest_mac[31:24];
            6'd3:  hdr_byte = cfg.dest_mac[23:16];
            6'd4:  hdr_byte = cfg.dest_mac[15:8];
            6'd5:  hdr_byte = cfg.dest_mac[7:0];
            6'd6:  hdr_byte = cfg.source_mac[47:40];
            6'd7:  hdr_byte = cfg.source_mac[39:32];
            6'd8:  hdr_byte = cfg.source_mac[31:24];
            6'd9:  hdr_byte = cfg.source_mac[23:16];
            6'd10: hdr_byte = cfg.source_mac[15:8];
            6'd11: hdr_byte = cfg.source_mac[7:0];
            6'd12: hdr_byte = ETH_TYPE_HI;
            6'd14: hdr_byte = IP_W_VER[15:8];
            6'd16: hdr_byte = ctx.ip_len[15:8];
            6'd17: hdr_byte = ctx.ip_len[7:0];
            6'd20: hdr_byte = IP_W_FLAGS[15:8];
            6'd22: hdr_byte = IP_W_TTLPR[15:8];
            6'd23: hdr_byte = IP_W_TTLPR[7:0];
            6'd24: hdr_byte = ctx.cksum[15:8];
            6'd25: hdr_byte = ctx.cksum[7:0];
            6'd26: hdr_byte = cfg.source_ip[31:24];
            6'd27: hdr_byte = cfg.source_ip[23:16];
            6'd28: hdr_byte = cfg.source_ip[15:8];
            6'd29: hdr_byte = cfg.source_ip[7:0];
            6'd30: hdr_byte = cfg.dest_ip[31:24];
            6'd31: hdr_byte = cfg.dest_ip[23:16];
            6'd32: hdr_byte = cfg.dest_ip[15:8];
            6'd33: hdr_byte = cfg.dest_ip[7:0];
            6'd34: hdr_byte = cfg.src_port[15:8];
            6'd35: hdr_byte = cfg.src_port[7:0];
            6'd36: hdr_byte = cfg.dest_port[15:8];
            6'd37: hdr_byte = cfg.dest_port[7:0];
            6'd38: hdr_byte = ctx.udp_len[15:8];
            6'd39: hdr_byte = ctx.udp_len[7:0];
            6'd42: hdr_byte = MARKER[0];
            6'd43: hdr_byte = MARKER[1];
            6'd44: hdr_byte = MARKER[2];
            6'd45: hdr_byte = MARKER[3];
            6'd46: hdr_byte = MARKER[4];
            6'd47: hdr_byte = MARKER[5];
            6'd48: hdr_byte = MARKER[6];
            6'd49: hdr_byte = MARKER[7];
            6'd52: hdr_byte = ctx.seq_number[31:24];
            6'd53: hdr_byte = ctx.seq_number[23:16];
            6'd54: hdr_byte = ctx.seq_number[15:8];
            6'd55: hdr_byte = ctx.seq_number[7:0];
            // zero fields: type low, TOS, id, fragment offset, UDP checksum,
            // marker terminator and padding
            default: hdr_byte = 8'h00;
        endcase
    end

endmodule

`default_nettype wire

[dv/tb_udp_ipv4_frame_builder.sv]
// Self-checking testbench for the UDP/IPv4 frame builder: directed corner frames, then random
// frame sequences under several address settings, with bursty input and a stalling receiver.
// Depends on design/ufb_pkg.sv and design/udp_ipv4_frame_builder.sv.
`default_nettype none

module tb_udp_ipv4_frame_builder
    import ufb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // One output beat as the builder should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       overrun;
    } frame_beat_t;

    localparam int DRAIN_CYCLES = 64;   // a full header burst plus margin

    // Every input starts at a known value; the rest of the run drives them at negedge.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // payload_len[10:0], seq_number[42:11],
                                           // payload_byte[50:43], zero pad
    logic                  s_tuser  = 1'b0; // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;  // frame_byte
    logic                  m_tlast;  // frame_last
    logic                  m_tuser;  // overrun

    // Shadow of the builder: address registers and payload tracking.
    logic [47:0] shadow_dest_mac;
    logic [47:0] shadow_source_mac;
    logic [31:0] shadow_source_ip;
    logic [31:0] shadow_dest_ip;
    logic [15:0] shadow_src_port;
    logic [15:0] shadow_dest_port;
    int unsigned payload_left;
    bit          frame_open;

    frame_beat_t beats_due[$];   // frame beats still owed by the builder, oldest first
    frame_beat_t due_beat;
    int          mismatch_cnt;
    int          items_sent;
    int          burst_left;
    int          rdy_mode;
    int          rdy_span;

    always #4 clk = ~clk;

    udp_ipv4_frame_builder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Expected frame bytes. A start beat yields the whole 56-byte header;
    // a data beat yields either a payload byte or an overrun flag.
    // ------------------------------------------------------------------
    task automatic predict_frame_beats(input op_t op, input logic [10:0] len,
                                       input logic [31:0] seq, input logic [7:0] pbyte);
        logic [7:0]  hdr [HDR_BYTES];
        logic [7:0]  marker_bytes [8];
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [31:0] csum;
        int unsigned plen;
        begin
            marker_bytes = '{8'h42, 8'h6f, 8'h6b, 8'h61, 8'h4d, 8'h61, 8'h72, 8'h65};
            if (op == OP_START)
            begin
                // clamp oversized lengths to the largest payload the frame holds
                plen    = (len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : len;
                ip_len  = 16'(plen + 42);
                udp_len = 16'(plen + 22);
                for (int i = 0; i < 6; i++)
                begin
                    hdr[i]     = shadow_dest_mac[40 - 8*i +: 8];
                    hdr[6 + i] = shadow_source_mac[40 - 8*i +: 8];
                end
                hdr[12] = 8'h08;  hdr[13] = 8'h00;
                hdr[14] = 8'h45;  hdr[15] = 8'h00;
                hdr[16] = ip_len[15:8];  hdr[17] = ip_len[7:0];
                hdr[18] = 8'h00;  hdr[19] = 8'h00;
                hdr[20] = 8'h40;  hdr[21] = 8'h00;
                hdr[22] = 8'h1e;  hdr[23] = 8'h11;
                for (int i = 0; i < 4; i++)
                begin
                    hdr[26 + i] = shadow_source_ip[24 - 8*i +: 8];
                    hdr[30 + i] = shadow_dest_ip[24 - 8*i +: 8];
                end
                // one's-complement sum of the IPv4 header with the checksum field at zero
                hdr[24] = 8'h00;  hdr[25] = 8'h00;
                csum = 0;
                for (int i = 14; i < 34; i += 2)
                    csum += {hdr[i], hdr[i + 1]};
                while (csum[31:16] != 0)
                    csum = csum[31:16] + csum[15:0];
                csum = ~csum;
                hdr[24] = csum[15:8];  hdr[25] = csum[7:0];
                hdr[34] = shadow_src_port[15:8];     hdr[35] = shadow_src_port[7:0];
                hdr[36] = shadow_dest_port[15:8];    hdr[37] = shadow_dest_port[7:0];
                hdr[38] = udp_len[15:8];  hdr[39] = udp_len[7:0];
                hdr[40] = 8'h00;  hdr[41] = 8'h00;
                for (int i = 0; i < 8; i++)
                    hdr[42 + i] = marker_bytes[i];
                hdr[50] = 8'h00;  hdr[51] = 8'h00;
                for (int i = 0; i < 4; i++)
                    hdr[52 + i] = seq[24 - 8*i +: 8];
                for (int i = 0; i < HDR_BYTES; i++)
                    beats_due.push_back(frame_beat_t'{data: hdr[i],
                                                      last: (plen == 0 && i == HDR_BYTES - 1),
                                                      overrun: 1'b0});
                // a start mid-frame simply abandons the old frame
                payload_left = plen;
                frame_open   = (plen != 0);
            end
            else if (!frame_open || payload_left == 0)
            begin
                // surplus byte: drop it and flag the overrun
                frame_open   = 1'b0;
                payload_left = 0;
                beats_due.push_back(frame_beat_t'{data: 8'h00, last: 1'b0, overrun: 1'b1});
            end
            else
            begin
                payload_left--;
                if (payload_left == 0)
                    frame_open = 1'b0;
                beats_due.push_back(frame_beat_t'{data: pbyte, last: (payload_left == 0),
                                                  overrun: 1'b0});
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: send one beat, idling in bursts. Valid stays high from
    // one beat to the next inside a burst; a gap lowers it for a while.
    // ------------------------------------------------------------------
    task automatic send_beat(input op_t op, input logic [10:0] len,
                             input logic [31:0] seq, input logic [7:0] pbyte);
        int gap;
        begin
            @(negedge clk);
            gap = 0;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                    gap = $urandom_range(1, 6);
            end
            burst_left--;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= {5'b0, pbyte, seq, len};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            items_sent++;
            predict_frame_beats(op, len, seq, pbyte);
        end
    endtask

    // Drop valid, let every owed beat arrive, then allow a header burst's worth of cycles.
    task automatic wait_frames_drained();
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (beats_due.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Register write: setup cycle, then access cycle; the register loads at the access edge.
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= CFG_ADDR_W'(int'(idx) * 8);
            pwdata  <= value;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            case (idx)
                REG_DEST_MAC:    shadow_dest_mac    = value[47:0];
                REG_SOURCE_MAC:  shadow_source_mac  = value[47:0];
                REG_SOURCE_IP:   shadow_source_ip   = value[31:0];
                REG_DEST_IP:     shadow_dest_ip     = value[31:0];
                REG_SRC_PORT:    shadow_src_port    = value[15:0];
                REG_DEST_PORT:   shadow_dest_port   = value[15:0];
                default: ;
            endcase
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    task automatic program_addresses(input logic [47:0] dmac, input logic [47:0] smac,
                                     input logic [31:0] sip, input logic [31:0] dip,
                                     input logic [15:0] sport, input logic [15:0] dport);
        begin
            write_reg(REG_DEST_MAC, 64'(dmac));
            write_reg(REG_SOURCE_MAC, 64'(smac));
            write_reg(REG_SOURCE_IP, 64'(sip));
            write_reg(REG_DEST_IP, 64'(dip));
            write_reg(REG_SRC_PORT, 64'(sport));
            write_reg(REG_DEST_PORT, 64'(dport));
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: the receiver stalls in spans of three moods - always
    // ready, lightly stalled and heavily stalled.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rdy_span == 0)
        begin
            rdy_mode = $urandom_range(0, 2);
            rdy_span = $urandom_range(8, 80);
        end
        rdy_span--;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    function automatic void check_field(input string name, input logic [7:0] expv,
                                        input logic [7:0] actv);
        if (actv !== expv)
        begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, expv, actv);
            mismatch_cnt++;
        end
    endfunction

    // Compare each accepted output beat with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (beats_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %02h last %0b overrun %0b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatch_cnt++;
            end
            else
            begin
                due_beat = beats_due.pop_front();
                check_field("frame_byte", due_beat.data, m_tdata);
                check_field("frame_last", 8'(due_beat.last), 8'(m_tlast));
                check_field("overrun", 8'(due_beat.overrun), 8'(m_tuser));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero addresses straight after reset: empty frame, then a stray byte.
    task automatic test_reset_state();
        begin
            send_beat(OP_START, 11'd0, 32'h0000_0000, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0000_0000, 8'h77);
        end
    endtask

    // All-ones addresses and a mixed pattern, each with a short frame.
    task automatic test_address_extremes();
        begin
            wait_frames_drained();
            program_addresses('1, '1, '1, '1, '1, '1);
            send_beat(OP_START, 11'd1, 32'hFFFF_FFFF, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'hFF);
            wait_frames_drained();
            program_addresses(48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 32'hC0A8_0001,
                              32'h0A00_0002, 16'h1234, 16'h8000);
            send_beat(OP_START, 11'd2, 32'h1234_5678, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h5A);
        end
    endtask

    // Oversized length, start during a frame, surplus bytes, largest length, empty frame.
    task automatic test_frame_corners();
        begin
            send_beat(OP_START, 11'h7FF, 32'h8000_0001, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h11);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h22);
            send_beat(OP_START, 11'd3, 32'h7FFF_FFFF, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'hFF);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'hA5);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h3C);
            send_beat(OP_START, 11'(MAX_PAYLOAD_DEF), 32'h0000_0000, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h81);
            send_beat(OP_START, 11'd0, 32'hDEAD_BEEF, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h42);
        end
    endtask

    // Hold the sender mid-frame until the builder has delivered everything owed.
    task automatic test_pause_mid_frame();
        begin
            send_beat(OP_START, 11'd6, 32'h0F0F_F0F0, 8'h00);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h01);
            send_beat(OP_DATA, 11'd0, 32'h0, 8'h02);
            wait_frames_drained();
            for (int i = 3; i <= 6; i++)
                send_beat(OP_DATA, 11'd0, 32'h0, 8'(i));
        end
    endtask

    // Random frames under four address settings. Most frames are well formed; some are cut
    // short, some carry surplus bytes, some declare huge lengths, and a few stray bytes appear.
    task automatic test_random_frames();
        int          base;
        int          pick;
        int          count;
        logic [10:0] len;
        begin
            base = items_sent;
            for (int phase = 0; phase < 4; phase++)
            begin
                wait_frames_drained();
                program_addresses(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  $urandom, $urandom, 16'($urandom), 16'($urandom));
                while (items_sent < base + 24 * (phase + 1))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                    begin
                        send_beat(OP_DATA, 11'($urandom), $urandom, 8'($urandom));
                        continue;
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                        len = 11'($urandom_range(0, 12));
                    else if (pick < 93)
                        len = 11'($urandom_range(13, 48));
                    else
                        len = 11'($urandom_range(1024, 2047));
                    // huge lengths are abandoned after a few bytes
                    count = (len > 48) ? $urandom_range(0, 8) : len;
                    pick = $urandom_range(0, 99);
                    if (pick < 10 && count > 0)
                        count = $urandom_range(0, count - 1);
                    else if (pick < 20)
                        count += $urandom_range(1, 2);
                    send_beat(OP_START, len, $urandom, 8'($urandom));
                    for (int i = 0; i < count; i++)
                        send_beat(OP_DATA, 11'($urandom), $urandom, 8'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        shadow_dest_mac    = '0;
        shadow_source_mac  = '0;
        shadow_source_ip   = '0;
        shadow_dest_ip     = '0;
        shadow_src_port    = '0;
        shadow_dest_port   = '0;
        payload_left       = 0;
        frame_open         = 1'b0;
        mismatch_cnt       = 0;
        items_sent         = 0;
        burst_left         = 0;
        rdy_mode           = 0;
        rdy_span           = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_address_extremes();
        test_frame_corners();
        test_pause_mid_frame();
        test_random_frames();

        wait_frames_drained();
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/ufb_pkg.sv
design/ufb_cfg_regs.sv
design/ufb_hdr_gen.sv
design/udp_ipv4_frame_builder.sv
dv/tb_udp_ipv4_frame_builder.sv
